/* rtl/mbc_pkg.sv */
// shared types, constants and round function of the magma block cipher
package mbc_pkg;

   localparam int ROUNDS      = 32;
   localparam int ROUND_W     = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
   localparam int KEY_SLOTS   = 32;
   localparam int SLOT_W      = $clog2(KEY_SLOTS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OP_W        = 2;
   localparam int BLOCK_W     = 64;
   localparam int HALF_W      = 32;
   localparam int ROT         = 11;

   localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);

   // request op codes
   localparam logic [OP_W-1:0] OP_ENCRYPT = 2'd0;
   localparam logic [OP_W-1:0] OP_DECRYPT = 2'd1;
   localparam logic [OP_W-1:0] OP_LOAD    = 2'd2;

   typedef enum logic [1:0] {
      KIND_ENCRYPT,
      KIND_DECRYPT,
      KIND_LOAD
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [BLOCK_W-1:0]   data_block;
      logic [SLOT_W-1:0]    key_slot;
      logic [HALF_W-1:0]    key_word;
   } cmd_type;

   // gost r 34.12-2015 substitution boxes, box n serves nibble n from the lsb
   localparam logic [3:0] SBOX [0:7][0:15] = '{
      '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
        4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
      '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
        4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
      '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
        4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
      '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
        4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
      '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
        4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
      '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
        4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
      '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
        4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
      '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
        4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
   };

   function automatic logic [HALF_W-1:0] substitute(input logic [HALF_W-1:0] w);
      logic [HALF_W-1:0] r;
      r = '0;
      for (int n = 0; n < 8; n++) begin
         r[4*n +: 4] = SBOX[n][w[4*n +: 4]];
      end
      return r;
   endfunction

   // add key mod 2^32, substitute, rotate left
   function automatic logic [HALF_W-1:0] round_fn(input logic [HALF_W-1:0] half,
                                                  input logic [HALF_W-1:0] key);
      logic [HALF_W-1:0] t;
      t = substitute(half + key);
      return (t << ROT) | (t >> (HALF_W - ROT));
   endfunction

   // key slot used by a round, reversed order for decryption
   function automatic logic [SLOT_W-1:0] key_slot_of(input logic [ROUND_W-1:0] rnd,
                                                     input logic rev);
      logic [ROUND_W-1:0] idx;
      idx = rev ? ROUND_W'(ROUND_LAST - rnd) : rnd;
      return SLOT_W'(idx % KEY_SLOTS);
   endfunction

endpackage

/* rtl/mbc_req_if.sv */
// request channel interface of the magma block cipher
interface mbc_req_if;
   logic                         valid;
   logic                         ready;
   logic [mbc_pkg::OP_W-1:0]     op;
   logic [mbc_pkg::BLOCK_W-1:0]  data_block;
   logic [mbc_pkg::SLOT_W-1:0]   key_slot;
   logic [mbc_pkg::HALF_W-1:0]   key_word;

   modport source (output valid, output op, output data_block, output key_slot,
                   output key_word, input ready);
   modport sink   (input valid, input op, input data_block, input key_slot,
                   input key_word, output ready);
endinterface

/* rtl/mbc_rsp_if.sv */
// response channel interface of the magma block cipher
interface mbc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mbc_pkg::BLOCK_W-1:0]  result_block;

   modport source (output valid, output result_block, input ready);
   modport sink   (input valid, input result_block, output ready);
endinterface

/* rtl/mbc_front.sv */
// front end: accepts requests and classifies them into queue commands
module mbc_front (
   mbc_req_if.sink           req_chan,
   input  logic              queue_full,
   output logic              push_valid,
   output mbc_pkg::cmd_type  push_cmd
);

   logic known_op;

   always_comb begin
      known_op      = 1'b1;
      push_cmd.kind = mbc_pkg::KIND_ENCRYPT;
      unique case (req_chan.op)
         mbc_pkg::OP_ENCRYPT: push_cmd.kind = mbc_pkg::KIND_ENCRYPT;
         mbc_pkg::OP_DECRYPT: push_cmd.kind = mbc_pkg::KIND_DECRYPT;
         mbc_pkg::OP_LOAD:    push_cmd.kind = mbc_pkg::KIND_LOAD;
         default:             known_op      = 1'b0;
      endcase
      push_cmd.data_block = req_chan.data_block;
      push_cmd.key_slot   = req_chan.key_slot;
      push_cmd.key_word   = req_chan.key_word;
   end

   // unused op code is taken and dropped
   assign req_chan.ready = !queue_full;
   assign push_valid     = req_chan.valid && !queue_full && known_op;

endmodule

/* rtl/mbc_queue.sv */
// command queue between front end and round engine
module mbc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  mbc_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output mbc_pkg::cmd_type  pop_cmd
);

   mbc_pkg::cmd_type                entry_ff [mbc_pkg::QUEUE_DEPTH];
   logic [mbc_pkg::QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [mbc_pkg::QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [mbc_pkg::QUEUE_AW:0]      count_ff, count_in;
   logic                            do_push, do_pop;

   assign full      = (count_ff == (mbc_pkg::QUEUE_AW+1)'(mbc_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == mbc_pkg::QUEUE_AW'(mbc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == mbc_pkg::QUEUE_AW'(mbc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/mbc_engine.sv */
// round engine: key store, one feistel round per cycle, response register
module mbc_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  mbc_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   mbc_rsp_if.source         rsp_chan
);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type                       state_ff, state_in;
   logic [mbc_pkg::ROUND_W-1:0]     round_ff, round_in;
   logic                            rev_ff, rev_in;
   logic [mbc_pkg::HALF_W-1:0]      left_ff, left_in;
   logic [mbc_pkg::HALF_W-1:0]      right_ff, right_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [mbc_pkg::BLOCK_W-1:0]     rsp_data_ff, rsp_data_in;

   logic [mbc_pkg::HALF_W-1:0]      key_mem [mbc_pkg::KEY_SLOTS];
   logic [mbc_pkg::HALF_W-1:0]      key_rd_ff;
   logic [mbc_pkg::SLOT_W-1:0]      key_addr;
   logic                            key_we;
   logic [mbc_pkg::HALF_W-1:0]      mixed;
   logic                            start;

   assign mixed = left_ff ^ mbc_pkg::round_fn(right_ff, key_rd_ff);
   assign start = (state_ff == ST_IDLE) && cmd_valid && (cmd.kind != mbc_pkg::KIND_LOAD)
                  && !rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      rev_in       = rev_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      cmd_pop      = 1'b0;
      key_we       = 1'b0;
      key_addr     = mbc_pkg::key_slot_of(round_ff, rev_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd.kind == mbc_pkg::KIND_LOAD) begin
               key_we  = 1'b1;
               cmd_pop = 1'b1;
            end else if (start) begin
               cmd_pop  = 1'b1;
               rev_in   = (cmd.kind == mbc_pkg::KIND_DECRYPT);
               round_in = '0;
               left_in  = cmd.data_block[mbc_pkg::BLOCK_W-1:mbc_pkg::HALF_W];
               right_in = cmd.data_block[mbc_pkg::HALF_W-1:0];
               key_addr = mbc_pkg::key_slot_of('0, rev_in);
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (round_ff == mbc_pkg::ROUND_LAST) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {mixed, right_ff};
               state_in     = ST_IDLE;
            end else begin
               left_in  = right_ff;
               right_in = mixed;
               round_in = round_ff + 1'b1;
               key_addr = mbc_pkg::key_slot_of(round_in, rev_ff);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      round_ff    <= round_in;
      rev_ff      <= rev_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      rsp_data_ff <= rsp_data_in;
   end

   // key store, registered read feeds the next round
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[cmd.key_slot] <= cmd.key_word;
      end
      key_rd_ff <= key_mem[key_addr];
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_block = rsp_data_ff;

   a_start_empty_out: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && cmd.kind != mbc_pkg::KIND_LOAD) |-> !rsp_valid_ff)
      else $error("block started while response register busy");

   a_rsp_from_last_round: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RUN && round_ff == mbc_pkg::ROUND_LAST))
      else $error("response raised outside the last round");

   a_no_pop_while_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> !cmd_pop && !key_we)
      else $error("queue popped or key written during rounds");

   a_round_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && state_in == ST_RUN) |=> (round_ff == '0))
      else $error("round counter not cleared at block start");

endmodule

/* rtl/magma_block_cipher.sv */
// magma 64-bit block cipher core top level
//
// req_chan carries one request per valid/ready handshake: op selects encrypt,
// decrypt or load of one round key (key_slot, key_word); op 3 is taken and dropped
// rsp_chan returns one result_block for each encrypt or decrypt request, in order
// requests land in a two-entry command queue; the front end stays ready while the
// queue has room, so it keeps taking requests while the round engine is busy
// a key load is written into the key store by the idle engine and gives no response
// a block takes a dispatch step and then 32 rounds, one feistel round per
// cycle through the single round unit; the round key is read from the key store
// in the cycle before its round
// blocks are worked one at a time, and the next block starts only after the
// response register has emptied
// the engine starts a block only once the response register is empty, so a
// stalled receiver holds the engine and then fills the queue, dropping ready
// reset clears the queue, engine state and response valid; round keys are not
// cleared and must be loaded before a block uses them
module magma_block_cipher (
   input  logic        clock,
   input  logic        reset,
   mbc_req_if.sink     req_chan,
   mbc_rsp_if.source   rsp_chan
);

   // front to queue
   logic              push_valid;
   mbc_pkg::cmd_type  push_cmd;
   logic              queue_full;

   // queue to engine
   logic              cmd_valid;
   logic              cmd_pop;
   mbc_pkg::cmd_type  cmd;

   // decode of the request op
   mbc_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   // decouples request acceptance from the round engine
   mbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (cmd_pop),
      .pop_valid  (cmd_valid),
      .pop_cmd    (cmd)
   );

   // key store, rounds and response register
   mbc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

/* tb/magma_block_cipher_tb.sv */
// self-checking testbench of the magma block cipher core
`timescale 1ns / 100ps

module magma_block_cipher_tb;

   // op code the core takes and drops
   localparam logic [mbc_pkg::OP_W-1:0] OP_SPARE = 2'd3;

   // cycles with no handshake on either channel before the run is abandoned
   localparam int QUIET_LIMIT = 2000;

   // cycles left to the core after the last response
   localparam int DRAIN_CYCLES = 40;

   // random requests sent in each of the three idling phases
   localparam int PHASE_ITEMS = 600;

   // standard gost r 34.12-2015 magma substitution boxes, box n serves nibble n from the lsb
   localparam logic [3:0] NIBBLE_BOX [8][16] = '{
      '{4'hc, 4'h4, 4'h6, 4'h2, 4'ha, 4'h5, 4'hb, 4'h9,
        4'he, 4'h8, 4'hd, 4'h7, 4'h0, 4'h3, 4'hf, 4'h1},
      '{4'h6, 4'h8, 4'h2, 4'h3, 4'h9, 4'ha, 4'h5, 4'hc,
        4'h1, 4'he, 4'h4, 4'h7, 4'hb, 4'hd, 4'h0, 4'hf},
      '{4'hb, 4'h3, 4'h5, 4'h8, 4'h2, 4'hf, 4'ha, 4'hd,
        4'he, 4'h1, 4'h7, 4'h4, 4'hc, 4'h9, 4'h6, 4'h0},
      '{4'hc, 4'h8, 4'h2, 4'h1, 4'hd, 4'h4, 4'hf, 4'h6,
        4'h7, 4'h0, 4'ha, 4'h5, 4'h3, 4'he, 4'h9, 4'hb},
      '{4'h7, 4'hf, 4'h5, 4'ha, 4'h8, 4'h1, 4'h6, 4'hd,
        4'h0, 4'h9, 4'h3, 4'he, 4'hb, 4'h4, 4'h2, 4'hc},
      '{4'h5, 4'hd, 4'hf, 4'h6, 4'h9, 4'h2, 4'hc, 4'ha,
        4'hb, 4'h7, 4'h8, 4'h1, 4'h4, 4'h3, 4'he, 4'h0},
      '{4'h8, 4'he, 4'h2, 4'h5, 4'h6, 4'h9, 4'h1, 4'hc,
        4'hf, 4'h4, 4'hb, 4'h0, 4'hd, 4'ha, 4'h3, 4'h7},
      '{4'h1, 4'h7, 4'he, 4'hd, 4'h0, 4'h5, 4'h8, 4'h3,
        4'h4, 4'hf, 4'ha, 4'h6, 4'h9, 4'hc, 4'hb, 4'h2}
   };

   // round keys of the standard's worked example; the key slots take them forward
   // three times over and then once backward
   localparam logic [mbc_pkg::HALF_W-1:0] SAMPLE_KEYS [8] = '{
      32'hffeeddcc, 32'hbbaa9988, 32'h77665544, 32'h33221100,
      32'hf0f1f2f3, 32'hf4f5f6f7, 32'hf8f9fafb, 32'hfcfdfeff
   };

   // mirrors the key store and keeps the blocks still owed by the core, oldest first
   class cipher_scoreboard;
      logic [mbc_pkg::HALF_W-1:0]  round_keys [mbc_pkg::KEY_SLOTS];
      logic [mbc_pkg::BLOCK_W-1:0] owed_blocks [$];
      int                          errors = 0;
      int                          results_seen = 0;

      function automatic logic [mbc_pkg::HALF_W-1:0] round_mix(
         logic [mbc_pkg::HALF_W-1:0] half,
         logic [mbc_pkg::HALF_W-1:0] key);
         logic [mbc_pkg::HALF_W-1:0] sum;
         logic [mbc_pkg::HALF_W-1:0] subst;
         sum = half + key;
         for (int n = 0; n < 8; n++) begin
            subst[4*n +: 4] = NIBBLE_BOX[n][sum[4*n +: 4]];
         end
         return {subst[mbc_pkg::HALF_W-mbc_pkg::ROT-1:0],
                 subst[mbc_pkg::HALF_W-1:mbc_pkg::HALF_W-mbc_pkg::ROT]};
      endfunction

      function automatic logic [mbc_pkg::BLOCK_W-1:0] crypt_block(
         logic [mbc_pkg::BLOCK_W-1:0] blk,
         bit backward);
         logic [mbc_pkg::HALF_W-1:0] left;
         logic [mbc_pkg::HALF_W-1:0] right;
         logic [mbc_pkg::HALF_W-1:0] mixed;
         int                         slot;
         left  = blk[mbc_pkg::BLOCK_W-1:mbc_pkg::HALF_W];
         right = blk[mbc_pkg::HALF_W-1:0];
         for (int r = 0; r < mbc_pkg::ROUNDS; r++) begin
            slot  = (backward ? mbc_pkg::ROUNDS - 1 - r : r) % mbc_pkg::KEY_SLOTS;
            mixed = left ^ round_mix(right, round_keys[slot]);
            if (r < mbc_pkg::ROUNDS - 1) begin
               left  = right;
               right = mixed;
            end else begin
               left = mixed;
            end
         end
         return {left, right};
      endfunction

      function void note_request(logic [mbc_pkg::OP_W-1:0] op,
                                 logic [mbc_pkg::BLOCK_W-1:0] blk,
                                 logic [mbc_pkg::SLOT_W-1:0] slot,
                                 logic [mbc_pkg::HALF_W-1:0] word);
         case (op)
            mbc_pkg::OP_LOAD:
               round_keys[slot] = word;
            mbc_pkg::OP_ENCRYPT:
               owed_blocks.insert(owed_blocks.size(), crypt_block(blk, 1'b0));
            mbc_pkg::OP_DECRYPT:
               owed_blocks.insert(owed_blocks.size(), crypt_block(blk, 1'b1));
            default: ;
         endcase
      endfunction

      task automatic report_mismatch(string what, logic [mbc_pkg::BLOCK_W-1:0] want,
                                     logic [mbc_pkg::BLOCK_W-1:0] got);
         errors++;
         $display("%0t: response %0d %s: expected %h, got %h",
                  $realtime, results_seen, what, want, got);
      endtask

      task automatic check_block(logic [mbc_pkg::BLOCK_W-1:0] got);
         logic [mbc_pkg::BLOCK_W-1:0] want;
         if (owed_blocks.size() == 0) begin
            report_mismatch("with no request pending", 'x, got);
         end else begin
            want = owed_blocks.pop_front();
            if (got !== want) report_mismatch("result_block", want, got);
         end
         results_seen++;
      endtask

      function int pending();
         return owed_blocks.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   mbc_req_if req_chan ();
   mbc_rsp_if rsp_chan ();

   magma_block_cipher u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   cipher_scoreboard sb;

   // percent of cycles in which each side holds back
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles  = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // response side: check each accepted block, then decide whether to stall next cycle
   always @(posedge clock) begin
      if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         sb.check_block(rsp_chan.result_block);
      end
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // give up once neither channel has moved for too long
   always @(posedge clock) begin
      if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("magma_block_cipher_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // present one request and hold it until the core takes it; entered and
   // left right after a rising edge, so valid changes at most once per edge
   task automatic send_request(logic [mbc_pkg::OP_W-1:0] op,
                               logic [mbc_pkg::BLOCK_W-1:0] blk,
                               logic [mbc_pkg::SLOT_W-1:0] slot,
                               logic [mbc_pkg::HALF_W-1:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.op         <= op;
      req_chan.data_block <= blk;
      req_chan.key_slot   <= slot;
      req_chan.key_word   <= word;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      sb.note_request(op, blk, slot, word);
   endtask

   // operands lean on the all-zero and all-one corners now and then
   function automatic logic [mbc_pkg::BLOCK_W-1:0] pick_block();
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   function automatic logic [mbc_pkg::HALF_W-1:0] pick_word();
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // mostly blocks, some key reloads between them, a few dropped op codes;
   // every key slot was loaded beforehand so a block never reads an empty slot
   task automatic send_random_requests(int count);
      int                        pick;
      logic [mbc_pkg::OP_W-1:0]  op;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 45)      op = mbc_pkg::OP_ENCRYPT;
         else if (pick < 85) op = mbc_pkg::OP_DECRYPT;
         else if (pick < 95) op = mbc_pkg::OP_LOAD;
         else                op = OP_SPARE;
         send_request(op, pick_block(),
                      mbc_pkg::SLOT_W'($urandom_range(mbc_pkg::KEY_SLOTS - 1)),
                      pick_word());
      end
   endtask

   initial begin
      // keep every request input known before the first edge
      req_chan.valid      = 1'b0;
      req_chan.op         = mbc_pkg::OP_ENCRYPT;
      req_chan.data_block = '0;
      req_chan.key_slot   = '0;
      req_chan.key_word   = '0;

      sb = new();

      // phase one idling also covers the directed requests
      send_idle_pct = 8;
      recv_idle_pct = 75;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // key schedule of the worked example, data_block of a load is don't care
      for (int s = 0; s < mbc_pkg::KEY_SLOTS; s++) begin
         send_request(mbc_pkg::OP_LOAD, {$urandom(), $urandom()}, mbc_pkg::SLOT_W'(s),
                      SAMPLE_KEYS[(s < 24) ? (s % 8) : (7 - s % 8)]);
      end

      // example plaintext and its ciphertext, then corner blocks both ways
      send_request(mbc_pkg::OP_ENCRYPT, 64'hfedcba9876543210, '0, '0);
      send_request(mbc_pkg::OP_DECRYPT, 64'h4ee901e5c2d8ca3d, '1, '1);
      send_request(mbc_pkg::OP_ENCRYPT, '0, '0, '0);
      send_request(mbc_pkg::OP_ENCRYPT, '1, '1, '1);
      send_request(mbc_pkg::OP_DECRYPT, '0, '0, '1);
      send_request(mbc_pkg::OP_DECRYPT, '1, '1, '0);

      // dropped op code between blocks leaves nothing behind
      send_request(OP_SPARE, '1, '1, '1);
      send_request(mbc_pkg::OP_ENCRYPT, 64'h0123456789abcdef, '0, '0);

      // key corners at the first and last slot, loaded while blocks are queued
      send_request(mbc_pkg::OP_LOAD, '1, '0, '0);
      send_request(mbc_pkg::OP_LOAD, '0, mbc_pkg::SLOT_W'(mbc_pkg::KEY_SLOTS - 1), '1);
      send_request(mbc_pkg::OP_ENCRYPT, 64'h8000000000000001, '0, '0);
      send_request(mbc_pkg::OP_DECRYPT, 64'h7ffffffffffffffe, '0, '0);
      send_request(mbc_pkg::OP_LOAD, '1, '1, '1);
      send_request(mbc_pkg::OP_LOAD, '0, '0, '1);
      send_request(mbc_pkg::OP_ENCRYPT, '1, '0, '0);
      send_request(mbc_pkg::OP_DECRYPT, '0, '1, '1);

      send_random_requests(PHASE_ITEMS);

      // slow sender, eager receiver
      send_idle_pct = 75;
      recv_idle_pct = 8;
      send_random_requests(PHASE_ITEMS);

      // both sides flat out
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_requests(PHASE_ITEMS);

      req_chan.valid <= 1'b0;

      // wait for every owed block, then let trailing loads settle
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0) begin
         $display("magma_block_cipher_tb passed");
      end else begin
         $display("magma_block_cipher_tb failed");
      end
      $finish;
   end

endmodule
